// ----- src/urtb_pkg.sv -----
// Shared types and constants for the serial port byte buffering block.
package urtb_pkg;

    localparam int CMD_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LINE_BYTE = 3'd0,
        CMD_TX_EMPTY  = 3'd1,
        CMD_SW_WRITE  = 3'd2,
        CMD_SW_READ   = 3'd3,
        CMD_STATUS    = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_REFUSED = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    // Requests from the event decoder to one ring
    typedef struct packed {
        logic push;
        logic pop;
    } ring_ctrl_t;

    // Occupancy flags from one ring
    typedef struct packed {
        logic full;
        logic empty;
        logic not_empty_next;
    } ring_stat_t;

endpackage

// ----- src/urtb_ring.sv -----
// One byte ring with a free slot kept, registered pop data.
module urtb_ring #(
    parameter int ADDR_BITS = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  urtb_pkg::ring_ctrl_t        ctrl,
    input  logic [urtb_pkg::BYTE_W-1:0] push_data,
    output urtb_pkg::ring_stat_t        stat,
    output logic [urtb_pkg::BYTE_W-1:0] pop_data
);
    import urtb_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [BYTE_W-1:0]    mem [DEPTH];
    logic [ADDR_BITS-1:0] head_reg;
    logic [ADDR_BITS-1:0] head_next;
    logic [ADDR_BITS-1:0] tail_reg;
    logic [ADDR_BITS-1:0] tail_next;
    logic [BYTE_W-1:0]    pop_data_reg;

    always_comb
    begin
        head_next = ctrl.push ? head_reg + 1'b1 : head_reg;
        tail_next = ctrl.pop  ? tail_reg + 1'b1 : tail_reg;
    end

    assign stat.full           = (head_reg + 1'b1) == tail_reg;
    assign stat.empty          = head_reg == tail_reg;
    assign stat.not_empty_next = head_next != tail_next;
    assign pop_data            = pop_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Storage: write at head, read at tail, read data held until next pop
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[head_reg] <= push_data;
        end
        if (ctrl.pop)
        begin
            pop_data_reg <= mem[tail_reg];
        end
    end

endmodule

// ----- src/uart_rx_tx_ring_buffers.sv -----
// Top level: event decoder, receive and transmit rings, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | into      | in_valid / in_stall  | cmd, data_byte
//  out     | out of    | out_valid / out_stall| send_valid, send_byte, read_valid,
//          |           |                      | read_byte, status, rx_not_empty,
//          |           |                      | tx_pending, tx_busy
//
// Events: one event per cycle while in_stall is low; its result is registered
// and appears in the result register in the cycle after the transaction.
// Reset clears pointers, the running flag and the result valid; ring storage
// is not cleared, as the pointers never allow a stale slot to be read.
// Stalls: in_stall follows a held result, so a new event is taken when the
// result register is empty or is being emptied in the same cycle.
module uart_rx_tx_ring_buffers #(
    parameter int RING_ADDR_BITS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [urtb_pkg::CMD_W-1:0]    cmd,
    input  logic [urtb_pkg::BYTE_W-1:0]   data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          send_valid,
    output logic [urtb_pkg::BYTE_W-1:0]   send_byte,
    output logic                          read_valid,
    output logic [urtb_pkg::BYTE_W-1:0]   read_byte,
    output logic [urtb_pkg::STATUS_W-1:0] status,
    output logic                          rx_not_empty,
    output logic                          tx_pending,
    output logic                          tx_busy
);
    import urtb_pkg::*;

    logic              accept;
    ring_ctrl_t        rx_ctrl;
    ring_ctrl_t        tx_ctrl;
    ring_stat_t        rx_stat;
    ring_stat_t        tx_stat;
    logic [BYTE_W-1:0] rx_pop_data;
    logic [BYTE_W-1:0] tx_pop_data;

    logic              running_reg;
    logic              running_next;

    // Per-event decode results before the result register
    logic              send_valid_d;
    logic              send_ring_d;
    logic [BYTE_W-1:0] send_byte_d;
    logic              read_valid_d;
    status_t           status_d;

    // Result register
    logic              out_valid_reg;
    logic              send_valid_reg;
    logic              send_ring_reg;
    logic [BYTE_W-1:0] send_byte_reg;
    logic              read_valid_reg;
    status_t           status_reg;
    logic              rx_not_empty_reg;
    logic              tx_pending_reg;
    logic              tx_busy_reg;

    // Hold the input while a finished result waits to be taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Event decoder: one ring slot and a pointer compare per event
    always_comb
    begin
        rx_ctrl      = '0;
        tx_ctrl      = '0;
        running_next = running_reg;
        send_valid_d = 1'b0;
        send_ring_d  = 1'b0;
        send_byte_d  = '0;
        read_valid_d = 1'b0;
        status_d     = ST_OK;
        if (accept)
        begin
            unique case (cmd)
                CMD_LINE_BYTE:
                begin
                    // Drop the line byte when the receive ring is full
                    if (rx_stat.full)
                    begin
                        status_d = ST_DROPPED;
                    end
                    else
                    begin
                        rx_ctrl.push = 1'b1;
                    end
                end
                CMD_TX_EMPTY:
                begin
                    if (tx_stat.empty)
                    begin
                        running_next = 1'b0;
                    end
                    else
                    begin
                        tx_ctrl.pop  = 1'b1;
                        send_valid_d = 1'b1;
                        send_ring_d  = 1'b1;
                    end
                end
                CMD_SW_WRITE:
                begin
                    if (!running_reg)
                    begin
                        // Transmitter idle: hand the byte over at once
                        send_valid_d = 1'b1;
                        send_byte_d  = data_byte;
                        running_next = 1'b1;
                    end
                    else if (tx_stat.full)
                    begin
                        status_d = ST_REFUSED;
                    end
                    else
                    begin
                        tx_ctrl.push = 1'b1;
                    end
                end
                CMD_SW_READ:
                begin
                    if (rx_stat.empty)
                    begin
                        status_d = ST_EMPTY;
                    end
                    else
                    begin
                        rx_ctrl.pop  = 1'b1;
                        read_valid_d = 1'b1;
                    end
                end
                default:
                begin
                    // Status query and unused codes change nothing
                    status_d = ST_OK;
                end
            endcase
        end
    end

    urtb_ring #(
        .ADDR_BITS (RING_ADDR_BITS)
    ) u_rx_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rx_ctrl),
        .push_data (data_byte),
        .stat      (rx_stat),
        .pop_data  (rx_pop_data)
    );

    urtb_ring #(
        .ADDR_BITS (RING_ADDR_BITS)
    ) u_tx_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tx_ctrl),
        .push_data (data_byte),
        .stat      (tx_stat),
        .pop_data  (tx_pop_data)
    );

    // Control state: running flag and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on each transaction, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_valid_reg   <= send_valid_d;
            send_ring_reg    <= send_ring_d;
            send_byte_reg    <= send_byte_d;
            read_valid_reg   <= read_valid_d;
            status_reg       <= status_d;
            rx_not_empty_reg <= rx_stat.not_empty_next;
            tx_pending_reg   <= tx_stat.not_empty_next;
            tx_busy_reg      <= running_next;
        end
    end

    // Ring bytes arrive from the ring read registers, which hold until the next pop
    assign out_valid    = out_valid_reg;
    assign send_valid   = send_valid_reg;
    assign send_byte    = send_ring_reg ? tx_pop_data : send_byte_reg;
    assign read_valid   = read_valid_reg;
    assign read_byte    = read_valid_reg ? rx_pop_data : '0;
    assign status       = status_reg;
    assign rx_not_empty = rx_not_empty_reg;
    assign tx_pending   = tx_pending_reg;
    assign tx_busy      = tx_busy_reg;

    // A queued transmit byte implies the transmitter is running
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && tx_pending_reg |-> tx_busy_reg)
        else $error("transmit ring holds bytes while transmitter idle");

    // A direct write to an idle transmitter is sent at once and marks it running
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd == CMD_SW_WRITE) && !running_reg
        |=> out_valid && send_valid && tx_busy && (send_byte == $past(data_byte)))
        else $error("idle write not passed straight to transmitter");

    // One event cannot both send and read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(send_valid_reg && read_valid_reg))
        else $error("send and read in one result");

    // A successful read always reports ok
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && read_valid_reg |-> status_reg == ST_OK)
        else $error("read returned a byte with a fault status");

    // Never push into a full ring
    assert property (@(posedge clk) disable iff (!rst_n)
        !(rx_ctrl.push && rx_stat.full) && !(tx_ctrl.push && tx_stat.full))
        else $error("push into a full ring");

endmodule
